// ----- rtl/sfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfpd_pkg
// Shared types and constants of the sync framed packet deframer.
// ----------------------------------------------------------------------------
package sfpd_pkg;

    // sync pair '@','T'
    localparam logic [7:0] SYNC_FIRST  = 8'h40;
    localparam logic [7:0] SYNC_SECOND = 8'h54;
    localparam logic [7:0] SERIAL_MOD  = 8'h80;

    // input kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // result kinds
    localparam logic RES_DATA    = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'b1;

    localparam logic [15:0] MIN_VER_RESET = 16'd1;
    localparam logic [11:0] MAX_LEN_RESET = 12'd2048;

    // result queue depth, at least two
    localparam int unsigned FIFO_DEPTH = 4;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_VER_LO,
        PH_VER_HI,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_SERIAL,
        PH_FEAT_LO,
        PH_FEAT_HI,
        PH_CMD,
        PH_MODE,
        PH_PAYLOAD,
        PH_SUM0,
        PH_SUM1,
        PH_SUM2,
        PH_SUM3
    } phase_t;

    typedef struct packed {
        logic [15:0] min_sender_version;
        logic [11:0] max_data_len;
    } cfg_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [15:0] sender_version;
        logic [11:0] data_len;
        logic [7:0]  serial_no;
        logic [15:0] feature_addr;
        logic [7:0]  command;
        logic [7:0]  mode_bits;
        logic [31:0] checksum;
        logic        crc_present;
        logic        version_error;
        logic        lost_packets;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } parse_out_t;

endpackage

// ----- rtl/sfpd_in_if.sv -----
// ----------------------------------------------------------------------------
// sfpd_in_if
// Input byte channel: valid/ready handshake with kind and received byte.
// ----------------------------------------------------------------------------
interface sfpd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// ----- rtl/sfpd_out_if.sv -----
// ----------------------------------------------------------------------------
// sfpd_out_if
// Result channel: valid/ready handshake with data byte or frame summary.
// ----------------------------------------------------------------------------
interface sfpd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  data_byte;
    logic [15:0] sender_version;
    logic [11:0] data_len;
    logic [7:0]  serial_no;
    logic [15:0] feature_addr;
    logic [7:0]  command;
    logic [7:0]  mode_bits;
    logic [31:0] checksum;
    logic        crc_present;
    logic        version_error;
    logic        lost_packets;

    modport source (
        output valid, output result_kind, output data_byte, output sender_version,
        output data_len, output serial_no, output feature_addr, output command,
        output mode_bits, output checksum, output crc_present, output version_error,
        output lost_packets, input ready
    );
    modport sink (
        input valid, input result_kind, input data_byte, input sender_version,
        input data_len, input serial_no, input feature_addr, input command,
        input mode_bits, input checksum, input crc_present, input version_error,
        input lost_packets, output ready
    );
endinterface

// ----- rtl/sync_framed_packet_deframer_top.sv -----
// ----------------------------------------------------------------------------
// sync_framed_packet_deframer_top
// Results are queued in a registered FifoDepth-entry result queue for out_ch.
// Throughput: one request per cycle while the queue has room for two results;
// a last payload byte with no checksum yields two; one drains per ready cycle.
// Reset: rst_n clears the parser to sync hunt, re-arms the first-frame serial
// skip, empties the queue and loads the register reset values.
// ----------------------------------------------------------------------------
module sync_framed_packet_deframer_top #(
    parameter int unsigned FifoDepth = sfpd_pkg::FIFO_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sfpd_in_if.sink                           in_ch,
    sfpd_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [sfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [15:0] min_ver_reg;
    logic [11:0] max_len_reg;
    sfpd_pkg::cfg_t       cfg;
    sfpd_pkg::parse_out_t parse_res;
    logic                 accept;
    logic                 fifo_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ver_reg <= sfpd_pkg::MIN_VER_RESET;
            max_len_reg <= sfpd_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfpd_pkg::CFG_MIN_VER: min_ver_reg <= cfg_data[15:0];
                sfpd_pkg::CFG_MAX_LEN: max_len_reg <= cfg_data[11:0];
            endcase
        end
    end

    assign cfg.min_sender_version = min_ver_reg;
    assign cfg.max_data_len       = max_len_reg;

    assign in_ch.ready = fifo_room;
    assign accept      = in_ch.valid && in_ch.ready;

    sfpd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .kind    (in_ch.kind),
        .rx_byte (in_ch.rx_byte),
        .cfg     (cfg),
        .res     (parse_res)
    );

    sfpd_result_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (parse_res),
        .room      (fifo_room),
        .out_ch    (out_ch)
    );

endmodule

// ----- rtl/sfpd_parser.sv -----
// ----------------------------------------------------------------------------
// sfpd_parser
// Frame parse state machine: header capture, payload pass-through, summary.
// ----------------------------------------------------------------------------
module sfpd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                kind,
    input  logic [7:0]          rx_byte,
    input  sfpd_pkg::cfg_t      cfg,
    output sfpd_pkg::parse_out_t res
);

    sfpd_pkg::phase_t phase_reg, phase_next;
    logic [11:0] payload_count_reg, payload_count_next;
    logic        first_frame_reg, first_frame_next;
    logic [7:0]  prev_serial_reg, prev_serial_next;
    logic [15:0] ver_reg, ver_next;
    logic [11:0] len_reg, len_next;
    logic [7:0]  serial_reg, serial_next;
    logic [15:0] feat_reg, feat_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  mode_reg, mode_next;
    logic [31:0] sum_reg, sum_next;
    logic [1:0]  flags_reg, flags_next;

    logic [15:0] ver_full;
    logic [15:0] len_full;
    logic [7:0]  serial_expect;
    logic        data_out;
    logic        done;
    sfpd_pkg::result_t data_res;
    sfpd_pkg::result_t summ_res;

    assign ver_full      = {rx_byte, ver_reg[7:0]};
    assign len_full      = {rx_byte, len_reg[7:0]};
    assign serial_expect = (prev_serial_reg + 8'd1) % sfpd_pkg::SERIAL_MOD;

    always_comb
    begin
        phase_next         = phase_reg;
        payload_count_next = payload_count_reg;
        first_frame_next   = first_frame_reg;
        prev_serial_next   = prev_serial_reg;
        ver_next           = ver_reg;
        len_next           = len_reg;
        serial_next        = serial_reg;
        feat_next          = feat_reg;
        cmd_next           = cmd_reg;
        mode_next          = mode_reg;
        sum_next           = sum_reg;
        flags_next         = flags_reg;
        data_out           = 1'b0;
        done               = 1'b0;

        if (step)
        begin
            if (kind == sfpd_pkg::KIND_RESTART)
            begin
                first_frame_next = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    sfpd_pkg::PH_SYNC1:
                    begin
                        flags_next = '0;
                        if (rx_byte == sfpd_pkg::SYNC_FIRST)
                            phase_next = sfpd_pkg::PH_SYNC2;
                    end
                    sfpd_pkg::PH_SYNC2:
                    begin
                        phase_next = (rx_byte == sfpd_pkg::SYNC_SECOND) ?
                                     sfpd_pkg::PH_VER_LO : sfpd_pkg::PH_SYNC1;
                    end
                    sfpd_pkg::PH_VER_LO:
                    begin
                        ver_next   = {8'd0, rx_byte};
                        phase_next = sfpd_pkg::PH_VER_HI;
                    end
                    sfpd_pkg::PH_VER_HI:
                    begin
                        ver_next = ver_full;
                        if (ver_full < cfg.min_sender_version)
                            flags_next[0] = 1'b1;
                        phase_next = sfpd_pkg::PH_LEN_LO;
                    end
                    sfpd_pkg::PH_LEN_LO:
                    begin
                        len_next   = {4'd0, rx_byte};
                        phase_next = sfpd_pkg::PH_LEN_HI;
                    end
                    sfpd_pkg::PH_LEN_HI:
                    begin
                        len_next = len_full[11:0];
                        // oversized frame is dropped without a result
                        phase_next = (len_full > {4'd0, cfg.max_data_len}) ?
                                     sfpd_pkg::PH_SYNC1 : sfpd_pkg::PH_SERIAL;
                    end
                    sfpd_pkg::PH_SERIAL:
                    begin
                        serial_next = rx_byte;
                        if (first_frame_reg)
                            first_frame_next = 1'b0;
                        else if (rx_byte != serial_expect)
                            flags_next[1] = 1'b1;
                        prev_serial_next = rx_byte;
                        phase_next       = sfpd_pkg::PH_FEAT_LO;
                    end
                    sfpd_pkg::PH_FEAT_LO:
                    begin
                        feat_next  = {8'd0, rx_byte};
                        phase_next = sfpd_pkg::PH_FEAT_HI;
                    end
                    sfpd_pkg::PH_FEAT_HI:
                    begin
                        feat_next  = {rx_byte, feat_reg[7:0]};
                        phase_next = sfpd_pkg::PH_CMD;
                    end
                    sfpd_pkg::PH_CMD:
                    begin
                        cmd_next   = rx_byte;
                        phase_next = sfpd_pkg::PH_MODE;
                    end
                    sfpd_pkg::PH_MODE:
                    begin
                        mode_next = rx_byte;
                        sum_next  = '0;
                        if (len_reg != 12'd0)
                        begin
                            payload_count_next = '0;
                            phase_next         = sfpd_pkg::PH_PAYLOAD;
                        end
                        else if (rx_byte[0])
                            phase_next = sfpd_pkg::PH_SUM0;
                        else
                            done = 1'b1;
                    end
                    sfpd_pkg::PH_PAYLOAD:
                    begin
                        data_out           = 1'b1;
                        payload_count_next = payload_count_reg + 12'd1;
                        if (payload_count_next == len_reg)
                        begin
                            if (mode_reg[0])
                                phase_next = sfpd_pkg::PH_SUM0;
                            else
                                done = 1'b1;
                        end
                    end
                    sfpd_pkg::PH_SUM0:
                    begin
                        sum_next   = {24'd0, rx_byte};
                        phase_next = sfpd_pkg::PH_SUM1;
                    end
                    sfpd_pkg::PH_SUM1:
                    begin
                        sum_next   = {sum_reg[31:16], rx_byte, sum_reg[7:0]};
                        phase_next = sfpd_pkg::PH_SUM2;
                    end
                    sfpd_pkg::PH_SUM2:
                    begin
                        sum_next   = {sum_reg[31:24], rx_byte, sum_reg[15:0]};
                        phase_next = sfpd_pkg::PH_SUM3;
                    end
                    sfpd_pkg::PH_SUM3:
                    begin
                        sum_next = {rx_byte, sum_reg[23:0]};
                        done     = 1'b1;
                    end
                endcase
                if (done)
                    phase_next = sfpd_pkg::PH_SYNC1;
            end
        end
    end

    // result words
    always_comb
    begin
        data_res             = '0;
        data_res.result_kind = sfpd_pkg::RES_DATA;
        data_res.data_byte   = rx_byte;

        summ_res                = '0;
        summ_res.result_kind    = sfpd_pkg::RES_SUMMARY;
        summ_res.sender_version = ver_next;
        summ_res.data_len       = len_next;
        summ_res.serial_no      = serial_next;
        summ_res.feature_addr   = feat_next;
        summ_res.command        = cmd_next;
        summ_res.mode_bits      = mode_next;
        summ_res.checksum       = mode_next[0] ? sum_next : 32'd0;
        summ_res.crc_present    = mode_next[0];
        summ_res.version_error  = flags_next[0];
        summ_res.lost_packets   = flags_next[1];

        res        = '0;
        res.second = summ_res;
        if (data_out && done)
        begin
            res.count = 2'd2;
            res.first = data_res;
        end
        else if (data_out)
        begin
            res.count = 2'd1;
            res.first = data_res;
        end
        else if (done)
        begin
            res.count = 2'd1;
            res.first = summ_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= sfpd_pkg::PH_SYNC1;
            payload_count_reg <= '0;
            first_frame_reg   <= 1'b1;
            prev_serial_reg   <= '0;
            ver_reg           <= '0;
            len_reg           <= '0;
            serial_reg        <= '0;
            feat_reg          <= '0;
            cmd_reg           <= '0;
            mode_reg          <= '0;
            sum_reg           <= '0;
            flags_reg         <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            payload_count_reg <= payload_count_next;
            first_frame_reg   <= first_frame_next;
            prev_serial_reg   <= prev_serial_next;
            ver_reg           <= ver_next;
            len_reg           <= len_next;
            serial_reg        <= serial_next;
            feat_reg          <= feat_next;
            cmd_reg           <= cmd_next;
            mode_reg          <= mode_next;
            sum_reg           <= sum_next;
            flags_reg         <= flags_next;
        end
    end

endmodule

// ----- rtl/sfpd_result_fifo.sv -----
// ----------------------------------------------------------------------------
// sfpd_result_fifo
// Small result queue, takes up to two results per cycle and drives one out.
// ----------------------------------------------------------------------------
module sfpd_result_fifo #(
    parameter int unsigned Depth = sfpd_pkg::FIFO_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfpd_pkg::parse_out_t push_data,
    output logic                 room,
    sfpd_out_if.source           out_ch
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    sfpd_pkg::result_t entries_reg [Depth];
    sfpd_pkg::result_t head;

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [PtrW-1:0] wr_ptr_2nd;
    logic [1:0]      push_n;
    logic            pop;

    assign push_n     = push ? push_data.count : 2'd0;
    assign pop        = out_ch.valid && out_ch.ready;
    assign wr_ptr_2nd = ptr_inc(wr_ptr_reg);
    // space for the worst case of two results per request
    assign room       = (count_reg <= CntW'(Depth - 2));

    always_comb
    begin
        count_next  = count_reg + CntW'(push_n) - CntW'(pop);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        priority if (push_n == 2'd2)
            wr_ptr_next = ptr_inc(wr_ptr_2nd);
        else if (push_n == 2'd1)
            wr_ptr_next = wr_ptr_2nd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            entries_reg[wr_ptr_reg] <= push_data.first;
        if (push_n == 2'd2)
            entries_reg[wr_ptr_2nd] <= push_data.second;
    end

    assign head = entries_reg[rd_ptr_reg];

    assign out_ch.valid          = (count_reg != '0);
    assign out_ch.result_kind    = head.result_kind;
    assign out_ch.data_byte      = head.data_byte;
    assign out_ch.sender_version = head.sender_version;
    assign out_ch.data_len       = head.data_len;
    assign out_ch.serial_no      = head.serial_no;
    assign out_ch.feature_addr   = head.feature_addr;
    assign out_ch.command        = head.command;
    assign out_ch.mode_bits      = head.mode_bits;
    assign out_ch.checksum       = head.checksum;
    assign out_ch.crc_present    = head.crc_present;
    assign out_ch.version_error  = head.version_error;
    assign out_ch.lost_packets   = head.lost_packets;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the sync framed packet deframer against a cycle-free model of the
// parser. Each accepted request updates the model, which queues the payload
// bytes and frame summaries it expects, and every result taken from the block
// is compared with the oldest entry. Several register settings and idle and
// stall patterns are run, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int IDLE_SETTLE    = 4;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } rx_item_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [sfpd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sfpd_pkg::CFG_DATA_W-1:0] cfg_data;

    sfpd_in_if  byte_ch ();
    sfpd_out_if result_ch ();

    sync_framed_packet_deframer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (byte_ch),
        .out_ch    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // stimulus and expected results
    rx_item_t          rx_stream_q[$];
    sfpd_pkg::result_t frame_out_q[$];
    rx_item_t          next_item;

    // register copies
    logic [15:0] cfg_min_ver;
    logic [11:0] cfg_max_len;

    // parser state of the model
    sfpd_pkg::phase_t parse_ph;
    logic [11:0] payload_cnt;
    logic        first_frame;
    logic [7:0]  prev_serial;
    logic [15:0] hdr_ver;
    logic [15:0] hdr_len;
    logic [7:0]  hdr_serial;
    logic [15:0] hdr_feat;
    logic [7:0]  hdr_cmd;
    logic [7:0]  hdr_mode;
    logic [31:0] chk_accum;
    logic        ver_err;
    logic        serial_gap;

    // run control and statistics
    int send_idle_pct;
    int stall_pct;
    logic hold_req;
    logic hold_seen;
    int hold_left;
    int quiet_cycles;
    int framed_items;
    logic [7:0] gen_serial;
    int errors;
    int n_accepted;
    int n_restart;
    int n_data;
    int n_summary;
    int n_crc;
    int n_lost;
    int n_ver_err;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // model of the parser, one accepted request at a time
    // ------------------------------------------------------------------
    function void deframe_item(input logic kind, input logic [7:0] b);
        logic              frame_end;
        sfpd_pkg::result_t res;
        frame_end = 1'b0;
        if (kind == sfpd_pkg::KIND_RESTART)
        begin
            first_frame = 1'b1;
            n_restart++;
            return;
        end
        case (parse_ph)
            sfpd_pkg::PH_SYNC1:
            begin
                ver_err = 1'b0;
                serial_gap = 1'b0;
                if (b == sfpd_pkg::SYNC_FIRST)
                    parse_ph = sfpd_pkg::PH_SYNC2;
            end
            sfpd_pkg::PH_SYNC2:
                parse_ph = (b == sfpd_pkg::SYNC_SECOND) ? sfpd_pkg::PH_VER_LO
                                                        : sfpd_pkg::PH_SYNC1;
            sfpd_pkg::PH_VER_LO:
            begin
                hdr_ver = {8'h00, b};
                parse_ph = sfpd_pkg::PH_VER_HI;
            end
            sfpd_pkg::PH_VER_HI:
            begin
                hdr_ver[15:8] = b;
                if (hdr_ver < cfg_min_ver)
                    ver_err = 1'b1;
                parse_ph = sfpd_pkg::PH_LEN_LO;
            end
            sfpd_pkg::PH_LEN_LO:
            begin
                hdr_len = {8'h00, b};
                parse_ph = sfpd_pkg::PH_LEN_HI;
            end
            sfpd_pkg::PH_LEN_HI:
            begin
                hdr_len[15:8] = b;
                // oversized frames are dropped without a result
                parse_ph = (hdr_len > {4'h0, cfg_max_len}) ? sfpd_pkg::PH_SYNC1
                                                           : sfpd_pkg::PH_SERIAL;
            end
            sfpd_pkg::PH_SERIAL:
            begin
                hdr_serial = b;
                if (first_frame)
                    first_frame = 1'b0;
                else if (b != ((prev_serial + 8'd1) % sfpd_pkg::SERIAL_MOD))
                    serial_gap = 1'b1;
                prev_serial = b;
                parse_ph = sfpd_pkg::PH_FEAT_LO;
            end
            sfpd_pkg::PH_FEAT_LO:
            begin
                hdr_feat = {8'h00, b};
                parse_ph = sfpd_pkg::PH_FEAT_HI;
            end
            sfpd_pkg::PH_FEAT_HI:
            begin
                hdr_feat[15:8] = b;
                parse_ph = sfpd_pkg::PH_CMD;
            end
            sfpd_pkg::PH_CMD:
            begin
                hdr_cmd = b;
                parse_ph = sfpd_pkg::PH_MODE;
            end
            sfpd_pkg::PH_MODE:
            begin
                hdr_mode = b;
                chk_accum = '0;
                if (hdr_len != 16'd0)
                begin
                    payload_cnt = '0;
                    parse_ph = sfpd_pkg::PH_PAYLOAD;
                end
                else if (hdr_mode[0])
                    parse_ph = sfpd_pkg::PH_SUM0;
                else
                    frame_end = 1'b1;
            end
            sfpd_pkg::PH_PAYLOAD:
            begin
                res = '0;
                res.result_kind = sfpd_pkg::RES_DATA;
                res.data_byte = b;
                frame_out_q.push_back(res);
                n_data++;
                payload_cnt = payload_cnt + 12'd1;
                if ({4'h0, payload_cnt} == hdr_len)
                begin
                    if (hdr_mode[0])
                        parse_ph = sfpd_pkg::PH_SUM0;
                    else
                        frame_end = 1'b1;
                end
            end
            sfpd_pkg::PH_SUM0:
            begin
                chk_accum = {24'h000000, b};
                parse_ph = sfpd_pkg::PH_SUM1;
            end
            sfpd_pkg::PH_SUM1:
            begin
                chk_accum[15:8] = b;
                parse_ph = sfpd_pkg::PH_SUM2;
            end
            sfpd_pkg::PH_SUM2:
            begin
                chk_accum[23:16] = b;
                parse_ph = sfpd_pkg::PH_SUM3;
            end
            sfpd_pkg::PH_SUM3:
            begin
                chk_accum[31:24] = b;
                frame_end = 1'b1;
            end
        endcase
        if (frame_end)
        begin
            res = '0;
            res.result_kind    = sfpd_pkg::RES_SUMMARY;
            res.sender_version = hdr_ver;
            res.data_len       = hdr_len[11:0];
            res.serial_no      = hdr_serial;
            res.feature_addr   = hdr_feat;
            res.command        = hdr_cmd;
            res.mode_bits      = hdr_mode;
            res.checksum       = hdr_mode[0] ? chk_accum : 32'h0;
            res.crc_present    = hdr_mode[0];
            res.version_error  = ver_err;
            res.lost_packets   = serial_gap;
            frame_out_q.push_back(res);
            n_summary++;
            n_crc += hdr_mode[0];
            n_lost += serial_gap;
            n_ver_err += ver_err;
            parse_ph = sfpd_pkg::PH_SYNC1;
        end
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid   <= 1'b0;
            byte_ch.kind    <= sfpd_pkg::KIND_BYTE;
            byte_ch.rx_byte <= 8'h00;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                deframe_item(byte_ch.kind, byte_ch.rx_byte);
                n_accepted++;
            end
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (rx_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = rx_stream_q.pop_front();
                    byte_ch.valid   <= 1'b1;
                    byte_ch.kind    <= next_item.kind;
                    byte_ch.rx_byte <= next_item.value;
                end
                else
                    byte_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        sfpd_pkg::result_t got;
        sfpd_pkg::result_t want;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.result_kind    = result_ch.result_kind;
                got.data_byte      = result_ch.data_byte;
                got.sender_version = result_ch.sender_version;
                got.data_len       = result_ch.data_len;
                got.serial_no      = result_ch.serial_no;
                got.feature_addr   = result_ch.feature_addr;
                got.command        = result_ch.command;
                got.mode_bits      = result_ch.mode_bits;
                got.checksum       = result_ch.checksum;
                got.crc_present    = result_ch.crc_present;
                got.version_error  = result_ch.version_error;
                got.lost_packets   = result_ch.lost_packets;
                if (frame_out_q.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: unexpected result %p", $time, got);
                    errors++;
                end
                else
                begin
                    want = frame_out_q.pop_front();
                    if (got !== want)
                    begin
                        if (errors < MAX_REPORTS)
                        begin
                            $display("%0t: mismatch, expected %p", $time, want);
                            $display("%0t:           actual   %p", $time, got);
                        end
                        errors++;
                    end
                end
            end
            result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // long receiver hold-off, started by a toggle of hold_req
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("sync_framed_packet_deframer_top test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task push_item(input logic kind, input logic [7:0] value);
        rx_item_t item;
        item.kind = kind;
        item.value = value;
        rx_stream_q.push_back(item);
    endtask

    task write_reg(input logic [sfpd_pkg::CFG_IDX_W-1:0] idx,
                   input logic [sfpd_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sfpd_pkg::CFG_MIN_VER)
            cfg_min_ver = val;
        else
            cfg_max_len = val[11:0];
    endtask

    // sync, version, length; if it fits, rest of header, body, checksum if mode[0]
    task queue_frame(input logic [15:0] ver, input logic [15:0] len,
                     input logic [7:0] serial, input logic [15:0] feat,
                     input logic [7:0] cmd, input logic [7:0] mode);
        int start_size;
        start_size = rx_stream_q.size();
        push_item(sfpd_pkg::KIND_BYTE, sfpd_pkg::SYNC_FIRST);
        push_item(sfpd_pkg::KIND_BYTE, sfpd_pkg::SYNC_SECOND);
        push_item(sfpd_pkg::KIND_BYTE, ver[7:0]);
        push_item(sfpd_pkg::KIND_BYTE, ver[15:8]);
        push_item(sfpd_pkg::KIND_BYTE, len[7:0]);
        push_item(sfpd_pkg::KIND_BYTE, len[15:8]);
        if (len <= {4'h0, cfg_max_len})
        begin
            push_item(sfpd_pkg::KIND_BYTE, serial);
            push_item(sfpd_pkg::KIND_BYTE, feat[7:0]);
            push_item(sfpd_pkg::KIND_BYTE, feat[15:8]);
            push_item(sfpd_pkg::KIND_BYTE, cmd);
            push_item(sfpd_pkg::KIND_BYTE, mode);
            for (int i = 0; i < len; i++)
                push_item(sfpd_pkg::KIND_BYTE, 8'($urandom));
            if (mode[0])
                repeat (4) push_item(sfpd_pkg::KIND_BYTE, 8'($urandom));
        end
        framed_items += rx_stream_q.size() - start_size;
    endtask

    // mostly well formed frames, some noise, broken sync, restarts and cut-short headers
    task queue_random(input int goal);
        int start;
        int pick;
        int lmax;
        logic [15:0] ver;
        logic [15:0] len;
        logic [7:0] junk;
        start = framed_items;
        while (framed_items - start < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                lmax = $urandom_range(99) < 80 ? 6 : 40;
                if (lmax > cfg_max_len)
                    lmax = cfg_max_len;
                if ($urandom_range(99) < 85)
                    len = 16'($urandom_range(lmax, 0));
                else
                    len = 16'($urandom_range(65535, cfg_max_len + 1));
                ver = ($urandom_range(99) < 80) ? 16'($urandom_range(65535, cfg_min_ver))
                                                : 16'($urandom);
                if ($urandom_range(99) < 85)
                    gen_serial = (gen_serial + 8'd1) % sfpd_pkg::SERIAL_MOD;
                else
                    gen_serial = 8'($urandom);
                queue_frame(ver, len, gen_serial, 16'($urandom), 8'($urandom),
                            8'($urandom));
            end
            else if (pick < 83)
            begin
                // sync start followed by a wrong second byte
                junk = 8'($urandom);
                if (junk == sfpd_pkg::SYNC_SECOND)
                    junk = sfpd_pkg::SYNC_FIRST;
                push_item(sfpd_pkg::KIND_BYTE, sfpd_pkg::SYNC_FIRST);
                push_item(sfpd_pkg::KIND_BYTE, junk);
            end
            else if (pick < 90)
                push_item(sfpd_pkg::KIND_BYTE, 8'($urandom));
            else if (pick < 94)
                push_item(sfpd_pkg::KIND_RESTART, 8'($urandom));
            else
            begin
                // header cut short, the next frame lands in its fields
                push_item(sfpd_pkg::KIND_BYTE, sfpd_pkg::SYNC_FIRST);
                push_item(sfpd_pkg::KIND_BYTE, sfpd_pkg::SYNC_SECOND);
                repeat ($urandom_range(8, 1)) push_item(sfpd_pkg::KIND_BYTE, 8'($urandom));
            end
        end
    endtask

    // sampled on the falling edge so the driver and checker have settled
    task wait_idle();
        while (rx_stream_q.size() != 0 || byte_ch.valid || frame_out_q.size() != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sfpd_pkg::CFG_MIN_VER;
        cfg_data = '0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        framed_items = 0;
        gen_serial = 8'h00;
        errors = 0;
        n_accepted = 0;
        n_restart = 0;
        n_data = 0;
        n_summary = 0;
        n_crc = 0;
        n_lost = 0;
        n_ver_err = 0;
        cfg_min_ver = sfpd_pkg::MIN_VER_RESET;
        cfg_max_len = sfpd_pkg::MAX_LEN_RESET;
        parse_ph = sfpd_pkg::PH_SYNC1;
        payload_cnt = '0;
        first_frame = 1'b1;
        prev_serial = '0;
        hdr_ver = '0;
        hdr_len = '0;
        hdr_serial = '0;
        hdr_feat = '0;
        hdr_cmd = '0;
        hdr_mode = '0;
        chk_accum = '0;
        ver_err = 1'b0;
        serial_gap = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, register reset values
        push_item(sfpd_pkg::KIND_RESTART, 8'hFF);
        push_item(sfpd_pkg::KIND_BYTE, sfpd_pkg::SYNC_FIRST);
        // wrong second byte, not a new start
        push_item(sfpd_pkg::KIND_BYTE, sfpd_pkg::SYNC_FIRST);
        // stray while hunting
        push_item(sfpd_pkg::KIND_BYTE, sfpd_pkg::SYNC_SECOND);
        queue_frame(16'h0001, 16'hFFFF, 8'h00, 16'h0000, 8'h00, 8'h00);
        // version below minimum, empty payload, checksum present
        queue_frame(16'h0000, 16'h0000, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
        // restart inside the header, one payload byte and no checksum
        push_item(sfpd_pkg::KIND_BYTE, sfpd_pkg::SYNC_FIRST);
        push_item(sfpd_pkg::KIND_BYTE, sfpd_pkg::SYNC_SECOND);
        push_item(sfpd_pkg::KIND_BYTE, 8'hFF);
        push_item(sfpd_pkg::KIND_BYTE, 8'hFF);
        push_item(sfpd_pkg::KIND_BYTE, 8'h01);
        push_item(sfpd_pkg::KIND_BYTE, 8'h00);
        push_item(sfpd_pkg::KIND_RESTART, 8'h00);
        push_item(sfpd_pkg::KIND_BYTE, 8'h00);
        push_item(sfpd_pkg::KIND_BYTE, 8'h00);
        push_item(sfpd_pkg::KIND_BYTE, 8'h00);
        push_item(sfpd_pkg::KIND_BYTE, 8'h00);
        push_item(sfpd_pkg::KIND_BYTE, 8'h00);
        push_item(sfpd_pkg::KIND_BYTE, 8'h00);
        gen_serial = 8'h00;
        wait_idle();

        // any version accepted, payload exactly at the length limit, no idling
        write_reg(sfpd_pkg::CFG_MIN_VER, 16'h0000);
        write_reg(sfpd_pkg::CFG_MAX_LEN, 16'd300);
        queue_frame(16'h1234, 16'd300, (gen_serial + 8'd1) % sfpd_pkg::SERIAL_MOD,
                    16'h5AA5, 8'h3C, 8'h01);
        gen_serial = (gen_serial + 8'd1) % sfpd_pkg::SERIAL_MOD;
        queue_random(300);
        wait_idle();

        // every version but FFFF below minimum, only empty frames fit, sender idles
        write_reg(sfpd_pkg::CFG_MIN_VER, 16'hFFFF);
        write_reg(sfpd_pkg::CFG_MAX_LEN, 16'd0);
        send_idle_pct = 86;
        queue_random(250);
        wait_idle();

        // random minimum, short limit, receiver stalls
        write_reg(sfpd_pkg::CFG_MIN_VER, 16'($urandom));
        write_reg(sfpd_pkg::CFG_MAX_LEN, 16'($urandom_range(24, 3)));
        send_idle_pct = 0;
        stall_pct = 86;
        queue_random(250);
        wait_idle();

        // both sides idle now and then
        write_reg(sfpd_pkg::CFG_MIN_VER, 16'h8000);
        write_reg(sfpd_pkg::CFG_MAX_LEN, 16'd100);
        send_idle_pct = 30;
        stall_pct = 30;
        queue_random(300);
        wait_idle();

        // receiver holds off while the sender keeps going
        write_reg(sfpd_pkg::CFG_MIN_VER, 16'h0001);
        write_reg(sfpd_pkg::CFG_MAX_LEN, 16'd2048);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req <= ~hold_req;
        queue_random(300);
        wait_idle();

        repeat (8) @(posedge clk);
        if (frame_out_q.size() != 0)
            errors++;
        $display("covered %0d requests (%0d restarts) over six register settings",
                 n_accepted, n_restart);
        $display("results: %0d payload bytes, %0d summaries (%0d checksum, %0d lost, %0d version)",
                 n_data, n_summary, n_crc, n_lost, n_ver_err);
        if (errors == 0)
            $display("sync_framed_packet_deframer_top test passed");
        else
            $display("sync_framed_packet_deframer_top test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sfpd_pkg.sv
rtl/sfpd_in_if.sv
rtl/sfpd_out_if.sv
rtl/sfpd_parser.sv
rtl/sfpd_result_fifo.sv
rtl/sync_framed_packet_deframer_top.sv
test/tb_top.sv
